### rtl/core/uctc_pkg.sv
`default_nettype none
package uctc_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic [AddrWidth-1:0] ADDR_RANGE_LOW = 3'h0;
  localparam logic [AddrWidth-1:0] ADDR_RANGE_HIGH = 3'h4;

  localparam logic [CpWidth-1:0] RANGE_LOW_RST = 21'h004E00;
  localparam logic [CpWidth-1:0] RANGE_HIGH_RST = 21'h009FFF;

  typedef enum logic [1:0] {
    DEC_NONE   = 2'd0,
    DEC_CJK    = 2'd1,
    DEC_REJECT = 2'd2
  } dec_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       is_cjk;
    logic [1:0] verdict;
  } out_item_t;

  typedef struct packed {
    dec_t               decision;
    logic [1:0]         pending;
    logic [CpWidth-1:0] accum;
  } tok_state_t;

  localparam tok_state_t TOK_CLEAR = '{decision: DEC_NONE, pending: 2'd0, accum: '0};

endpackage
`default_nettype wire

### rtl/core/uctc_step.sv
`default_nettype none
module uctc_step (
  input  wire uctc_pkg::in_item_t        item,
  input  wire uctc_pkg::tok_state_t      cur,
  input  wire [uctc_pkg::CpWidth-1:0]    range_low,
  input  wire [uctc_pkg::CpWidth-1:0]    range_high,
  output uctc_pkg::tok_state_t           nxt,
  output uctc_pkg::out_item_t            result
);
  import uctc_pkg::*;

  logic [7:0]         b;
  logic [CpWidth-1:0] accum_sh;
  tok_state_t         upd;

  assign b = item.token_byte;
  assign accum_sh = {cur.accum[CpWidth-7:0], b[5:0]};

  always_comb begin
    upd = cur;
    if (cur.decision == DEC_NONE) begin
      if (cur.pending != 2'd0) begin
        upd.accum = accum_sh;
        upd.pending = cur.pending - 2'd1;
        if (cur.pending == 2'd1 && accum_sh >= range_low && accum_sh <= range_high) begin
          upd.decision = DEC_CJK;
        end
      end else if (!b[7]) begin
        if (b inside {[8'h21:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]}) begin
          upd.decision = DEC_REJECT;
        end
      end else if (b[7:5] == 3'b110) begin
        upd.pending = 2'd1;
        upd.accum = {{(CpWidth-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        upd.pending = 2'd2;
        upd.accum = {{(CpWidth-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        upd.pending = 2'd3;
        upd.accum = {{(CpWidth-3){1'b0}}, b[2:0]};
      end
    end
  end

  always_comb begin
    case (upd.decision)
      DEC_CJK: begin
        result.verdict = DEC_CJK;
        result.is_cjk = 1'b1;
      end
      DEC_REJECT: begin
        result.verdict = DEC_REJECT;
        result.is_cjk = 1'b0;
      end
      default: begin
        result.verdict = DEC_NONE;
        result.is_cjk = 1'b0;
      end
    endcase
  end

  assign nxt = item.last_byte ? TOK_CLEAR : upd;

endmodule
`default_nettype wire

### rtl/core/utf8_cjk_token_classifier.sv
`default_nettype none
// Classifies a token streamed as raw UTF-8 bytes, one byte per transfer on the in_ channel,
// with last_byte marking the token end. One verdict transfer comes out per token, on its last
// byte: DEC_CJK when a decoded 2/3/4-byte code point lies within [range_low, range_high],
// DEC_REJECT when an ASCII digit or punctuation byte was seen first, else DEC_NONE. A byte is
// taken every cycle unless a last byte waits in the input register for the result register;
// bytes pass an input register, then single-pass decode logic into the result register. A
// multibyte sequence cut short at the token end does not count. Range registers sit at byte
// addresses 0x0 and 0x4 and should be written only while no token is in flight.
module utf8_cjk_token_classifier (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire uctc_pkg::in_item_t        in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output uctc_pkg::out_item_t            out_data,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [uctc_pkg::AddrWidth-1:0]  paddr,
  input  wire [uctc_pkg::DataWidth-1:0]  pwdata,
  output logic [uctc_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);
  import uctc_pkg::*;

  logic [CpWidth-1:0] range_low_r, range_low_nxt;
  logic [CpWidth-1:0] range_high_r, range_high_nxt;
  logic               stage_v_r, stage_v_nxt;
  in_item_t           stage_r, stage_nxt;
  tok_state_t         tok_r, tok_nxt, step_state;
  logic               out_v_r, out_v_nxt;
  out_item_t          out_r, out_nxt, step_result;
  logic               cfg_wr, out_free, stage_adv;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == ADDR_RANGE_HIGH)
                ? {{(DataWidth-CpWidth){1'b0}}, range_high_r}
                : {{(DataWidth-CpWidth){1'b0}}, range_low_r};

  always_comb begin
    range_low_nxt = range_low_r;
    range_high_nxt = range_high_r;
    if (cfg_wr) begin
      if (paddr[2]) begin
        range_high_nxt = pwdata[CpWidth-1:0];
      end else begin
        range_low_nxt = pwdata[CpWidth-1:0];
      end
    end
  end

  uctc_step u_step (
    .item       (stage_r),
    .cur        (tok_r),
    .range_low  (range_low_r),
    .range_high (range_high_r),
    .nxt        (step_state),
    .result     (step_result)
  );

  // flow control
  assign out_free = !out_v_r || out_ready;
  assign stage_adv = stage_v_r && (!stage_r.last_byte || out_free);
  assign in_ready = !stage_v_r || stage_adv;
  assign out_valid = out_v_r;
  assign out_data = out_r;

  always_comb begin
    stage_v_nxt = stage_v_r;
    stage_nxt = stage_r;
    tok_nxt = tok_r;
    out_v_nxt = out_v_r;
    out_nxt = out_r;
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (stage_adv) begin
      stage_v_nxt = 1'b0;
      tok_nxt = step_state;
      if (stage_r.last_byte) begin
        out_v_nxt = 1'b1;
        out_nxt = step_result;
      end
    end
    if (in_valid && in_ready) begin
      stage_v_nxt = 1'b1;
      stage_nxt = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r <= RANGE_LOW_RST;
      range_high_r <= RANGE_HIGH_RST;
      stage_v_r <= 1'b0;
      tok_r <= TOK_CLEAR;
      out_v_r <= 1'b0;
    end else begin
      range_low_r <= range_low_nxt;
      range_high_r <= range_high_nxt;
      stage_v_r <= stage_v_nxt;
      tok_r <= tok_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    out_r <= out_nxt;
  end

  a_pending_undecided: assert property (@(posedge clk) disable iff (!rst_n)
    tok_r.pending != 2'd0 |-> tok_r.decision == DEC_NONE)
    else $error("continuation pending after decision");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    stage_adv && stage_r.last_byte |=> tok_r == TOK_CLEAR)
    else $error("token state not cleared after last byte");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.verdict != 2'd3 && out_r.is_cjk == (out_r.verdict == DEC_CJK))
    else $error("bad verdict encoding");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    stage_adv && stage_r.last_byte |=> out_v_r)
    else $error("last byte transfer produced no result");

endmodule
`default_nettype wire

### bench/cjk_verdict_monitor.sv
`timescale 1ns / 1ps
module cjk_verdict_monitor (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  input  wire                            in_ready,
  input  uctc_pkg::in_item_t             in_data,
  input  wire                            out_valid,
  input  wire                            out_ready,
  input  uctc_pkg::out_item_t            out_data,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire                            pready,
  input  wire [uctc_pkg::AddrWidth-1:0]  paddr,
  input  wire [uctc_pkg::DataWidth-1:0]  pwdata,
  output int                             mismatch_count,
  output int                             verdicts_due,
  output int                             verdicts_checked
);
  import uctc_pkg::*;

  logic [CpWidth-1:0] cjk_lo;
  logic [CpWidth-1:0] cjk_hi;
  dec_t               held;
  logic [1:0]         pend;
  logic [CpWidth-1:0] acc;
  out_item_t          verdicts_owed [$];
  int                 errs;
  int                 seen;

  function automatic logic rejects_token(input logic [7:0] b);
    return (b >= 8'h21) && (b <= 8'h7E) &&
           !((b >= 8'h41) && (b <= 8'h5A)) && !((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    if (held == DEC_NONE) begin
      if (pend != 2'd0) begin
        acc = {acc[CpWidth-7:0], b[5:0]};
        pend = pend - 2'd1;
        if (pend == 2'd0 && acc >= cjk_lo && acc <= cjk_hi) held = DEC_CJK;
      end else if (!b[7]) begin
        if (rejects_token(b)) held = DEC_REJECT;
      end else if (b[7:5] == 3'b110) begin
        pend = 2'd1;
        acc = '0;
        acc[4:0] = b[4:0];
      end else if (b[7:4] == 4'b1110) begin
        pend = 2'd2;
        acc = '0;
        acc[3:0] = b[3:0];
      end else if (b[7:3] == 5'b11110) begin
        pend = 2'd3;
        acc = '0;
        acc[2:0] = b[2:0];
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      cjk_lo = RANGE_LOW_RST;
      cjk_hi = RANGE_HIGH_RST;
      held = DEC_NONE;
      pend = 2'd0;
      acc = '0;
      verdicts_owed.delete();
      errs = 0;
      seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_RANGE_LOW) cjk_lo = pwdata[CpWidth-1:0];
        else if (paddr == ADDR_RANGE_HIGH) cjk_hi = pwdata[CpWidth-1:0];
      end
      if (out_valid && out_ready) begin
        got = out_data;
        seen++;
        if (verdicts_owed.size() == 0) begin
          errs++;
          $display("%0t: unexpected verdict transfer, expected none, got is_cjk %0d verdict %0d",
                   $time, got.is_cjk, got.verdict);
        end else begin
          want = verdicts_owed.pop_front();
          if (got.is_cjk !== want.is_cjk) begin
            errs++;
            $display("%0t: is_cjk expected %0d got %0d", $time, want.is_cjk, got.is_cjk);
          end
          if (got.verdict !== want.verdict) begin
            errs++;
            $display("%0t: verdict expected %0d got %0d", $time, want.verdict, got.verdict);
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data.token_byte);
        if (in_data.last_byte) begin
          want.verdict = held;
          want.is_cjk = (held == DEC_CJK);
          verdicts_owed = {verdicts_owed, want};
          held = DEC_NONE;
          pend = 2'd0;
          acc = '0;
        end
      end
    end
    mismatch_count <= errs;
    verdicts_due <= verdicts_owed.size();
    verdicts_checked <= seen;
  end

endmodule

### bench/tb_utf8_cjk_token_classifier.sv
`timescale 1ns / 1ps
module tb_utf8_cjk_token_classifier;
  import uctc_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  wire                  in_ready;
  in_item_t             in_data;
  wire                  out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  wire  [DataWidth-1:0] prdata;
  wire                  pready;

  int mismatch_count;
  int verdicts_due;
  int verdicts_checked;

  logic               steady;
  logic [CpWidth-1:0] range_lo_now;
  logic [CpWidth-1:0] range_hi_now;
  logic [7:0]         tok_q [$];
  int                 bytes_sent;
  int                 tokens_sent;
  int                 settings_used;

  // bit 8 flags the last byte of a token
  logic [8:0] opening [25] = '{
    9'h0E4, 9'h0B8, 9'h1AD,
    9'h131,
    9'h17A,
    9'h100,
    9'h1FF,
    9'h0E4, 9'h1B8,
    9'h0C3, 9'h131,
    9'h021, 9'h0E4, 9'h0B8, 9'h1AD,
    9'h0F0, 9'h09F, 9'h098, 9'h180,
    9'h0C0, 9'h180,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF
  };

  logic [CpWidth-1:0] lows  [8] = '{21'h004E00, 21'h000000, 21'h009FFF, 21'h003400,
                                    21'h000000, 21'h1FFFFF, 21'h000000, 21'h020000};
  logic [CpWidth-1:0] highs [8] = '{21'h009FFF, 21'h1FFFFF, 21'h004E00, 21'h004DBF,
                                    21'h000000, 21'h1FFFFF, 21'h000000, 21'h02A6DF};

  utf8_cjk_token_classifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  cjk_verdict_monitor u_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count   (mismatch_count),
    .verdicts_due     (verdicts_due),
    .verdicts_checked (verdicts_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int       gap;
    in_item_t item;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.token_byte = b;
    item.last_byte = fin;
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (fin) tokens_sent++;
  endtask

  task automatic send_token();
    int n;
    int k;
    n = tok_q.size();
    for (k = 0; k < n; k++) send_byte(tok_q[k], k == n - 1);
  endtask

  // wait until every verdict is back and the pipeline has emptied
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [AddrWidth-1:0] addr, input logic [CpWidth-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {{(DataWidth-CpWidth){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_range(input logic [CpWidth-1:0] lo, input logic [CpWidth-1:0] hi);
    write_reg(ADDR_RANGE_LOW, lo);
    write_reg(ADDR_RANGE_HIGH, hi);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    range_lo_now = lo;
    range_hi_now = hi;
    settings_used++;
  endtask

  task automatic push_code(input logic [CpWidth-1:0] cp, input int len, input int keep);
    logic [7:0] seq [4];
    int         k;
    case (len)
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (k = 0; k < keep; k++) begin
      // continuation tops are not checked by the decoder
      if (k > 0 && $urandom_range(0, 9) == 0) seq[k][7:6] = 2'($urandom_range(0, 3));
      tok_q = {tok_q, seq[k]};
    end
  endtask

  task automatic build_token();
    int                 units;
    int                 kind;
    int                 len;
    logic [CpWidth-1:0] cp;
    logic [7:0]         b;
    tok_q.delete();
    units = $urandom_range(1, 4);
    repeat (units) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        if (range_lo_now <= range_hi_now) begin
          cp = CpWidth'($urandom_range(range_lo_now, range_hi_now));
        end else begin
          cp = CpWidth'($urandom);
        end
        len = (cp <= 21'h7FF) ? 2 : (cp <= 21'hFFFF) ? 3 : 4;
        if (len < 4 && $urandom_range(0, 4) == 0) len++;
        push_code(cp, len, len);
      end else if (kind < 60) begin
        len = $urandom_range(2, 4);
        push_code(CpWidth'($urandom), len, len);
      end else if (kind < 75) begin
        case ($urandom_range(0, 3))
          0: b = 8'h41 + 8'($urandom_range(0, 25));
          1: b = 8'h61 + 8'($urandom_range(0, 25));
          2: b = 8'($urandom_range(0, 8'h20));
          default: b = 8'h7F;
        endcase
        tok_q = {tok_q, b};
      end else if (kind < 85) begin
        tok_q = {tok_q, 8'($urandom_range(0, 8'h7F))};
      end else if (kind < 93) begin
        len = $urandom_range(2, 4);
        push_code(CpWidth'($urandom), len, $urandom_range(1, len - 1));
      end else begin
        tok_q = {tok_q, 8'($urandom_range(0, 8'hFF))};
      end
    end
    // sequence cut short by the end of the token
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(2, 4);
      push_code(CpWidth'($urandom), len, $urandom_range(1, len - 1));
    end
  endtask

  initial begin
    int phase;
    int start;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady = 1'b0;
    range_lo_now = RANGE_LOW_RST;
    range_hi_now = RANGE_HIGH_RST;
    bytes_sent = 0;
    tokens_sent = 0;
    settings_used = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 25; i++) begin
      // code point extremes need the full range
      if (i == 19) begin
        settle();
        set_range(21'h000000, 21'h1FFFFF);
      end
      send_byte(opening[i][7:0], opening[i][8]);
    end

    for (phase = 0; phase < 8; phase++) begin
      settle();
      if (phase == 4) begin
        lows[4] = CpWidth'($urandom_range(0, 21'h1FFFFF));
        highs[4] = CpWidth'($urandom_range(lows[4], 21'h1FFFFF));
      end
      set_range(lows[phase], highs[phase]);
      steady = (phase % 3 == 2);
      start = bytes_sent;
      while (bytes_sent - start < 185) begin
        build_token();
        send_token();
        if ($urandom_range(0, 39) == 0) settle();
      end
    end
    settle();

    $display("covered %0d bytes in %0d tokens over %0d range settings", bytes_sent,
             tokens_sent, settings_used);
    $display("%0d verdict transfers checked", verdicts_checked);
    if (mismatch_count == 0 && verdicts_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/uctc_pkg.sv
rtl/core/uctc_step.sv
rtl/core/utf8_cjk_token_classifier.sv
bench/cjk_verdict_monitor.sv
bench/tb_utf8_cjk_token_classifier.sv
